@@ sv/tmh_pkg.sv @@
// Package with the shared types and constants of the timer min-heap.
`default_nettype none
package tmh_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W = 64;
	localparam int COUNT_W = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_POP = 2'd2;

	typedef enum logic [1:0] {
		KIND_INSERT,
		KIND_REMOVE,
		KIND_POP,
		KIND_NOP
	} kind_t;

	typedef enum logic [2:0] {
		ST_DONE = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY = 3'd4,
		ST_NOT_EXPIRED = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP_RD,
		S_POP_CHK,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DIV_WAIT,
		S_DEL,
		S_DEL_CAP,
		S_UP,
		S_UP_CMP,
		S_DN_L,
		S_DN_R,
		S_DN_CMP,
		S_DN_MOVE,
		S_PLACE,
		S_ROOT_RD
	} state_t;

	typedef struct packed {
		kind_t kind;
		logic [DATA_W-1:0] timer_id;
		logic [DATA_W-1:0] deadline;
		logic [DATA_W-1:0] bucket_width;
		logic [DATA_W-1:0] now_time;
	} item_t;

	typedef struct packed {
		logic start;
		logic [DATA_W-1:0] deadline;
		logic [DATA_W-1:0] bucket_width;
	} round_req_t;

	typedef struct packed {
		logic done;
		logic [DATA_W-1:0] rounded;
	} round_rsp_t;

endpackage
`default_nettype wire

@@ sv/timer_min_heap_top.sv @@
// Top level of the timer min-heap: front end, rounding unit and heap back end.
`default_nettype none
// Usage. A command is taken at a rising edge where start is high and busy is
// low. op selects insert, remove by id, or pop of the earliest expired timer.
// The front end classifies the command and holds up to two items in a queue;
// busy rises only when that queue is full, so a new item can be handed over
// while the back end is still working on the previous one.
// Each item produces exactly one result, shown for one cycle with done high.
// The receiver cannot hold results off; they must be taken when done is high.
// Steps per item: insert and remove search the stored ids one entry at a
// time, reading and then comparing each entry through the registered-read
// entry memories. Insert starts the rounding divider with the search; it
// produces one quotient bit per cycle, and the insert waits for it before
// the sift. Each sift level going up reads and compares the parent; each
// level going down reads the children and moves the smaller one up when
// it beats the moving entry. The root read and the result register come last.
// Reset clears the entry count and the queue; the memories need no clearing
// because only the contents of slots below the count are ever used.
module timer_min_heap_top #(
	parameter int CAPACITY = tmh_pkg::CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] op,
	input wire logic [tmh_pkg::DATA_W-1:0] timer_id,
	input wire logic [tmh_pkg::DATA_W-1:0] deadline,
	input wire logic [tmh_pkg::DATA_W-1:0] bucket_width,
	input wire logic [tmh_pkg::DATA_W-1:0] now_time,
	output logic done,
	output logic [2:0] status,
	output logic [tmh_pkg::DATA_W-1:0] popped_id,
	output logic [tmh_pkg::COUNT_W-1:0] entry_count,
	output logic min_valid,
	output logic [tmh_pkg::DATA_W-1:0] min_id,
	output logic [tmh_pkg::DATA_W-1:0] min_deadline
);
	import tmh_pkg::*;

	logic q_valid;
	logic q_pop;
	item_t q_item;
	round_req_t rnd_req;
	round_rsp_t rnd_rsp;

	// The front end decodes the op code so the back end works on kinds only.
	tmh_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.timer_id(timer_id), .deadline(deadline), .bucket_width(bucket_width),
		.now_time(now_time), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	// The rounding unit runs in parallel with the id search of an insert.
	tmh_round u_round (
		.clk(clk), .arst_n(arst_n), .req(rnd_req), .rsp(rnd_rsp)
	);

	tmh_back #(.CAPACITY(CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .rnd_req(rnd_req), .rnd_rsp(rnd_rsp), .done(done),
		.status(status), .popped_id(popped_id), .entry_count(entry_count),
		.min_valid(min_valid), .min_id(min_id), .min_deadline(min_deadline)
	);
endmodule
`default_nettype wire

@@ sv/tmh_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tmh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ sv/tmh_round.sv @@
// Bucket rounding unit: restoring division, one quotient bit per cycle.
`default_nettype none
module tmh_round (
	input wire logic clk,
	input wire logic arst_n,
	input wire tmh_pkg::round_req_t req,
	output tmh_pkg::round_rsp_t rsp
);
	import tmh_pkg::*;

	logic [DATA_W-1:0] sum_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] sh_q;
	logic [DATA_W-1:0] rem_q;
	logic [5:0] bit_q;
	logic run_q;
	logic done_q;
	logic [DATA_W:0] trial;
	logic [DATA_W:0] next_rem;

	always_comb begin
		trial = {rem_q, sh_q[DATA_W-1]};
		if (trial >= {1'b0, den_q}) begin
			next_rem = trial - {1'b0, den_q};
		end else begin
			next_rem = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			bit_q <= '0;
		end else if (req.start) begin
			// A zero width leaves the deadline as it is: remainder stays zero.
			run_q <= (req.bucket_width != '0);
			done_q <= (req.bucket_width == '0);
			bit_q <= '1;
		end else if (run_q) begin
			bit_q <= bit_q - 1'b1;
			if (bit_q == '0) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// With a zero width the half width is zero too, so the sum is the deadline.
			sum_q <= req.deadline + (req.bucket_width >> 1);
			den_q <= req.bucket_width;
			sh_q <= req.deadline + (req.bucket_width >> 1);
			rem_q <= '0;
		end else if (run_q) begin
			sh_q <= {sh_q[DATA_W-2:0], 1'b0};
			rem_q <= next_rem[DATA_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rounded = sum_q - rem_q;
endmodule
`default_nettype wire

@@ sv/tmh_front.sv @@
// Front end: accepts commands, classifies the op code and queues two items.
`default_nettype none
module tmh_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] op,
	input wire logic [tmh_pkg::DATA_W-1:0] timer_id,
	input wire logic [tmh_pkg::DATA_W-1:0] deadline,
	input wire logic [tmh_pkg::DATA_W-1:0] bucket_width,
	input wire logic [tmh_pkg::DATA_W-1:0] now_time,
	output logic q_valid,
	output tmh_pkg::item_t q_item,
	input wire logic q_pop
);
	import tmh_pkg::*;

	item_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;
	logic push;
	item_t in_item;

	always_comb begin
		in_item.timer_id = timer_id;
		in_item.deadline = deadline;
		in_item.bucket_width = bucket_width;
		in_item.now_time = now_time;
		unique case (op)
			OP_INSERT: in_item.kind = KIND_INSERT;
			OP_REMOVE: in_item.kind = KIND_REMOVE;
			OP_POP: in_item.kind = KIND_POP;
			default: in_item.kind = KIND_NOP;
		endcase
	end

	assign busy = fill_q[1];
	assign push = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign q_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end
endmodule
`default_nettype wire

@@ sv/tmh_back.sv @@
// Back end: id search and heap sift sequencer over the entry memories.
`default_nettype none
module tmh_back #(
	parameter int CAPACITY = tmh_pkg::CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire tmh_pkg::item_t q_item,
	output logic q_pop,
	output tmh_pkg::round_req_t rnd_req,
	input wire tmh_pkg::round_rsp_t rnd_rsp,
	output logic done,
	output logic [2:0] status,
	output logic [tmh_pkg::DATA_W-1:0] popped_id,
	output logic [tmh_pkg::COUNT_W-1:0] entry_count,
	output logic min_valid,
	output logic [tmh_pkg::DATA_W-1:0] min_id,
	output logic [tmh_pkg::DATA_W-1:0] min_deadline
);
	import tmh_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = CW + 1;

	state_t state_q, state_d;
	kind_t kind_q;
	status_t status_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] best_pos_q;
	logic best_sel_q;
	logic [DATA_W-1:0] best_id_q, best_dl_q;
	logic [DATA_W-1:0] id_q, now_q, popped_q;
	logic [DATA_W-1:0] cur_id_q, cur_dl_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [DATA_W-1:0] wid, wdl, rd_id, rd_dl;

	logic [IW-1:0] cnt_w, left_w, right_w;
	logic [AW-1:0] parent_a, last_a;
	logic at_last;

	assign cnt_w = IW'(cnt_q);
	assign left_w = (IW'(pos_q) << 1) + IW'(1);
	assign right_w = left_w + IW'(1);
	assign parent_a = (pos_q - AW'(1)) >> 1;
	assign last_a = AW'(cnt_q - CW'(1));
	assign at_last = (pos_q == last_a);

	tmh_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ids (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wid), .raddr(raddr), .rdata(rd_id)
	);
	tmh_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_dls (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdl), .raddr(raddr), .rdata(rd_dl)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					unique case (q_item.kind)
						KIND_INSERT, KIND_REMOVE: state_d = S_SRCH_RD;
						KIND_POP: state_d = (cnt_q == '0) ? S_ROOT_RD : S_POP_RD;
						default: state_d = S_ROOT_RD;
					endcase
				end
			end
			S_POP_RD: state_d = S_POP_CHK;
			S_POP_CHK: state_d = (rd_dl > now_q) ? S_ROOT_RD : S_DEL;
			S_SRCH_RD: begin
				if (idx_q == cnt_q) begin
					if (kind_q == KIND_INSERT && cnt_q != CW'(CAPACITY)) begin
						state_d = S_DIV_WAIT;
					end else begin
						state_d = S_ROOT_RD;
					end
				end else begin
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (rd_id == id_q) begin
					state_d = (kind_q == KIND_INSERT) ? S_ROOT_RD : S_DEL;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_DIV_WAIT: if (rnd_rsp.done) state_d = S_UP;
			S_DEL: state_d = at_last ? S_ROOT_RD : S_DEL_CAP;
			S_DEL_CAP: state_d = S_UP;
			S_UP: state_d = (pos_q == '0) ? S_DN_L : S_UP_CMP;
			S_UP_CMP: state_d = (cur_dl_q < rd_dl) ? S_UP : S_DN_L;
			S_DN_L: state_d = (left_w >= cnt_w) ? S_PLACE : S_DN_R;
			S_DN_R: state_d = (right_w < cnt_w) ? S_DN_CMP : S_DN_MOVE;
			S_DN_CMP: state_d = S_DN_MOVE;
			S_DN_MOVE: state_d = best_sel_q ? S_DN_L : S_PLACE;
			S_PLACE: state_d = S_ROOT_RD;
			S_ROOT_RD: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls and unit requests.
	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wid = cur_id_q;
		wdl = cur_dl_q;
		raddr = '0;
		q_pop = 1'b0;
		rnd_req.start = 1'b0;
		rnd_req.deadline = q_item.deadline;
		rnd_req.bucket_width = q_item.bucket_width;
		unique case (state_q)
			S_IDLE: begin
				q_pop = q_valid;
				rnd_req.start = q_valid && (q_item.kind == KIND_INSERT);
			end
			S_SRCH_RD: raddr = idx_q[AW-1:0];
			S_DEL: raddr = last_a;
			S_UP: raddr = parent_a;
			S_UP_CMP: begin
				if (cur_dl_q < rd_dl) begin
					we = 1'b1;
					wid = rd_id;
					wdl = rd_dl;
				end
			end
			S_DN_L: raddr = AW'(left_w);
			S_DN_R: raddr = AW'(right_w);
			S_DN_MOVE: begin
				we = best_sel_q;
				wid = best_id_q;
				wdl = best_dl_q;
			end
			S_PLACE: we = 1'b1;
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == S_ROOT_RD);
			if (state_q == S_DIV_WAIT && rnd_rsp.done) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (state_q == S_DEL) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				kind_q <= q_item.kind;
				id_q <= q_item.timer_id;
				now_q <= q_item.now_time;
				idx_q <= '0;
				popped_q <= '0;
				status_q <= (q_item.kind == KIND_POP && cnt_q == '0) ? ST_EMPTY : ST_DONE;
			end
			S_POP_CHK: begin
				pos_q <= '0;
				if (rd_dl > now_q) begin
					status_q <= ST_NOT_EXPIRED;
				end else begin
					popped_q <= rd_id;
				end
			end
			S_SRCH_RD: begin
				if (idx_q == cnt_q) begin
					if (kind_q == KIND_REMOVE) begin
						status_q <= ST_NOT_FOUND;
					end else if (cnt_q == CW'(CAPACITY)) begin
						status_q <= ST_FULL;
					end
				end
			end
			S_SRCH_CMP: begin
				pos_q <= idx_q[AW-1:0];
				idx_q <= idx_q + CW'(1);
				if (rd_id == id_q && kind_q == KIND_INSERT) begin
					status_q <= ST_DUPLICATE;
				end
			end
			S_DIV_WAIT: begin
				cur_id_q <= id_q;
				cur_dl_q <= rnd_rsp.rounded;
				pos_q <= AW'(cnt_q);
			end
			S_DEL_CAP: begin
				cur_id_q <= rd_id;
				cur_dl_q <= rd_dl;
			end
			S_UP_CMP: begin
				if (cur_dl_q < rd_dl) begin
					pos_q <= parent_a;
				end
			end
			S_DN_R: begin
				best_pos_q <= AW'(left_w);
				if (rd_dl < cur_dl_q) begin
					best_sel_q <= 1'b1;
					best_id_q <= rd_id;
					best_dl_q <= rd_dl;
				end else begin
					best_sel_q <= 1'b0;
					best_dl_q <= cur_dl_q;
				end
			end
			S_DN_CMP: begin
				if (rd_dl < best_dl_q) begin
					best_sel_q <= 1'b1;
					best_pos_q <= AW'(right_w);
					best_id_q <= rd_id;
					best_dl_q <= rd_dl;
				end
			end
			S_DN_MOVE: begin
				if (best_sel_q) begin
					pos_q <= best_pos_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Result registers; the root read was issued in the last sequencer step.
	always_ff @(posedge clk) begin
		if (state_q == S_ROOT_RD) begin
			status <= status_q;
			popped_id <= popped_q;
			entry_count <= COUNT_W'(cnt_q);
		end
	end

	logic root_valid_q;
	always_ff @(posedge clk) begin
		if (state_q == S_ROOT_RD) begin
			root_valid_q <= (cnt_q != '0);
		end
	end

	assign min_valid = root_valid_q;
	assign min_id = root_valid_q ? rd_id : '0;
	assign min_deadline = root_valid_q ? rd_dl : '0;
endmodule
`default_nettype wire

@@ dv/timer_min_heap_top_tb.sv @@
// Self-checking testbench for the timer min-heap top level.
`timescale 1ns / 1ps
`default_nettype none
module timer_min_heap_top_tb;
	import tmh_pkg::*;

	localparam int HEAP_CAP = CAPACITY_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	// One command as the driver applies it, and one predicted result.
	typedef struct {
		logic [1:0] op;
		logic [63:0] timer_id;
		logic [63:0] deadline;
		logic [63:0] bucket_width;
		logic [63:0] now_time;
		bit hold_for_drain;
	} cmd_t;

	typedef struct {
		logic [2:0] status;
		logic [63:0] popped_id;
		logic [6:0] entry_count;
		logic min_valid;
		logic [63:0] min_id;
		logic [63:0] min_deadline;
	} heap_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = OP_INSERT;
	logic [63:0] timer_id = '0;
	logic [63:0] deadline = '0;
	logic [63:0] bucket_width = '0;
	logic [63:0] now_time = '0;
	logic done;
	logic [2:0] status;
	logic [63:0] popped_id;
	logic [6:0] entry_count;
	logic min_valid;
	logic [63:0] min_id;
	logic [63:0] min_deadline;

	timer_min_heap_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.timer_id(timer_id),
		.deadline(deadline),
		.bucket_width(bucket_width),
		.now_time(now_time),
		.done(done),
		.status(status),
		.popped_id(popped_id),
		.entry_count(entry_count),
		.min_valid(min_valid),
		.min_id(min_id),
		.min_deadline(min_deadline)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow heap kept by the predictor; only slots below shadow_count are used.
	logic [63:0] shadow_ids [HEAP_CAP];
	logic [63:0] shadow_deadlines [HEAP_CAP];
	int shadow_count = 0;

	cmd_t pending_cmds [$];
	heap_result_t expected_results [$];
	// Ids handed to the generator so it can aim removes and duplicate inserts at live timers.
	logic [63:0] known_ids [$];
	int error_count = 0;
	int idle_cycles = 0;
	bit stimulus_done = 1'b0;
	// Set by the monitor when the item on the ports was taken at the last rising edge.
	bit took_item = 1'b0;
	logic [63:0] sim_now = 64'd1000;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic void swap_slots(int a, int b);
		logic [63:0] t;
		t = shadow_ids[a];
		shadow_ids[a] = shadow_ids[b];
		shadow_ids[b] = t;
		t = shadow_deadlines[a];
		shadow_deadlines[a] = shadow_deadlines[b];
		shadow_deadlines[b] = t;
	endfunction

	// Sift up, then sift down; the left child wins ties because only a
	// strictly smaller right child replaces the current best.
	function automatic void restore_heap(int pos);
		int up, best, l, r;
		if (pos >= shadow_count) return;
		while (pos > 0) begin
			up = (pos - 1) / 2;
			if (shadow_deadlines[pos] >= shadow_deadlines[up]) break;
			swap_slots(pos, up);
			pos = up;
		end
		forever begin
			best = pos;
			l = 2 * pos + 1;
			r = 2 * pos + 2;
			if (l < shadow_count && shadow_deadlines[l] < shadow_deadlines[best]) best = l;
			if (r < shadow_count && shadow_deadlines[r] < shadow_deadlines[best]) best = r;
			if (best == pos) break;
			swap_slots(pos, best);
			pos = best;
		end
	endfunction

	function automatic int locate_id(logic [63:0] id);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_ids[i] == id) return i;
		return -1;
	endfunction

	function automatic void delete_slot(int pos);
		int last;
		last = shadow_count - 1;
		if (pos != last) begin
			shadow_ids[pos] = shadow_ids[last];
			shadow_deadlines[pos] = shadow_deadlines[last];
		end
		shadow_count = last;
		restore_heap(pos);
	endfunction

	// Applies one accepted command to the shadow heap and returns its result.
	function automatic heap_result_t predict_heap_op(cmd_t c);
		heap_result_t res;
		logic [63:0] d;
		int pos;
		res.status = ST_DONE;
		res.popped_id = '0;
		case (c.op)
			OP_INSERT: begin
				if (locate_id(c.timer_id) >= 0) res.status = ST_DUPLICATE;
				else if (shadow_count >= HEAP_CAP) res.status = ST_FULL;
				else begin
					d = c.deadline;
					if (c.bucket_width != 0)
						d = (d + (c.bucket_width >> 1)) / c.bucket_width * c.bucket_width;
					shadow_ids[shadow_count] = c.timer_id;
					shadow_deadlines[shadow_count] = d;
					shadow_count++;
					restore_heap(shadow_count - 1);
				end
			end
			OP_REMOVE: begin
				pos = locate_id(c.timer_id);
				if (pos >= 0) delete_slot(pos);
				else res.status = ST_NOT_FOUND;
			end
			OP_POP: begin
				if (shadow_count == 0) res.status = ST_EMPTY;
				else if (shadow_deadlines[0] > c.now_time) res.status = ST_NOT_EXPIRED;
				else begin
					res.popped_id = shadow_ids[0];
					delete_slot(0);
				end
			end
			default: ;
		endcase
		res.entry_count = shadow_count[6:0];
		res.min_valid = shadow_count > 0;
		res.min_id = res.min_valid ? shadow_ids[0] : '0;
		res.min_deadline = res.min_valid ? shadow_deadlines[0] : '0;
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random gap: mostly none or short, now and then long.
	function automatic int random_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	task automatic queue_cmd(input logic [1:0] o, input logic [63:0] id,
			input logic [63:0] d, input logic [63:0] w, input logic [63:0] n,
			input bit hold = 1'b0);
		cmd_t c;
		c.op = o;
		c.timer_id = id;
		c.deadline = d;
		c.bucket_width = w;
		c.now_time = n;
		c.hold_for_drain = hold;
		pending_cmds.push_back(c);
		if (o == OP_INSERT) known_ids.push_back(id);
	endtask

	function automatic logic [63:0] pick_known_id();
		if (known_ids.size() == 0) return rand64();
		return known_ids[$urandom_range(0, known_ids.size() - 1)];
	endfunction

	// Stimulus: a directed opening, then random bursts. Ids are drawn from a
	// small pool often enough that duplicates and removes hit live timers.
	initial begin
		int burst_len;
		int p;
		logic [63:0] d;
		logic [63:0] w;
		// Pops and removes against an empty heap.
		queue_cmd(OP_POP, '0, '0, '0, '1);
		queue_cmd(OP_REMOVE, 64'd5, '0, '0, '0);
		// Field extremes, including the wrap of the rounding sum.
		queue_cmd(OP_INSERT, '1, '1, 64'd10, '0);
		queue_cmd(OP_INSERT, '0, '0, '0, '0);
		queue_cmd(OP_INSERT, 64'h8000_0000_0000_0001, 64'd17, '1, '0);
		queue_cmd(OP_INSERT, 64'd7, '1, '0, '0);
		queue_cmd(OP_INSERT, 64'd9, 64'd25, 64'd10, '0);
		queue_cmd(OP_INSERT, 64'd10, 64'd24, 64'd10, '0);
		queue_cmd(OP_INSERT, 64'd11, 64'h7fff_ffff_ffff_ffff, 64'd1, '0);
		// Duplicate id is rejected.
		queue_cmd(OP_INSERT, 64'd9, 64'd3, 64'd0, '0);
		// Pops at time zero and at the largest time; both find an expired timer.
		queue_cmd(OP_POP, '0, '0, '0, '0);
		queue_cmd(OP_POP, '1, '1, '1, '1);
		queue_cmd(OP_REMOVE, 64'd11, '0, '0, '0);
		queue_cmd(OP_REMOVE, 64'd12345, '0, '0, '0);
		// Unused op code leaves the state alone.
		queue_cmd(2'd3, '1, '1, '1, '1);
		// Fill the heap to capacity with tied deadlines, then overflow it.
		for (int i = 0; i < HEAP_CAP; i++)
			queue_cmd(OP_INSERT, 64'h100 + i, 64'd500 + (i % 3), 64'd0, '0);
		queue_cmd(OP_INSERT, 64'hdead, 64'd1, 64'd0, '0);
		queue_cmd(OP_INSERT, 64'h100, 64'd1, 64'd0, '0);
		queue_cmd(OP_REMOVE, 64'h100 + 31, '0, '0, '0);
		for (int i = 0; i < HEAP_CAP; i++)
			queue_cmd(OP_POP, '0, '0, '0, '1, i == 0);
		known_ids.delete();
		// Random part: insert-heavy and drain-heavy bursts keep the count moving
		// through its whole range.
		while (pending_cmds.size() < 1750) begin
			burst_len = $urandom_range(10, 80);
			p = $urandom_range(0, 2);
			for (int i = 0; i < burst_len; i++) begin
				int r;
				r = $urandom_range(0, 99);
				sim_now += $urandom_range(0, 40);
				if (r < (p == 0 ? 65 : (p == 1 ? 20 : 40))) begin
					d = ($urandom_range(0, 9) == 0) ? rand64() : sim_now + $urandom_range(0, 300);
					case ($urandom_range(0, 4))
						0: w = '0;
						1: w = rand64();
						default: w = $urandom_range(1, 64);
					endcase
					queue_cmd(OP_INSERT, ($urandom_range(0, 3) == 0) ? pick_known_id()
						: rand64(), d, w, rand64());
				end else if (r < 80) begin
					queue_cmd(OP_REMOVE, ($urandom_range(0, 4) == 0) ? rand64()
						: pick_known_id(), rand64(), rand64(), rand64());
				end else if (r < 98) begin
					queue_cmd(OP_POP, rand64(), rand64(), rand64(),
						($urandom_range(0, 9) == 0) ? rand64() : sim_now);
				end else begin
					queue_cmd(2'd3, rand64(), rand64(), rand64(), rand64());
				end
				if (known_ids.size() > 200) void'(known_ids.pop_front());
			end
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: presents one item at a time and holds it until it is taken at a
	// rising edge. Inputs move only on the falling edge.
	int gap_left = 0;
	bit waiting_drain = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (took_item) begin
				pending_cmds.pop_front();
				gap_left = random_gap();
			end
			if (start && !took_item) begin
				// Keep the same item on the ports.
			end else if (pending_cmds.size() == 0) begin
				start <= 1'b0;
				stimulus_done = 1'b1;
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (pending_cmds[0].hold_for_drain && expected_results.size() != 0) begin
				// Hold off until every result in flight has come back.
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				op <= pending_cmds[0].op;
				timer_id <= pending_cmds[0].timer_id;
				deadline <= pending_cmds[0].deadline;
				bucket_width <= pending_cmds[0].bucket_width;
				now_time <= pending_cmds[0].now_time;
			end
		end
	end

	// Monitor: predicts on acceptance and checks each strobed result.
	always @(posedge clk) begin
		cmd_t c;
		heap_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected done", 64'd1, 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) report_mismatch("status", status, want.status);
					if (popped_id !== want.popped_id)
						report_mismatch("popped_id", popped_id, want.popped_id);
					if (entry_count !== want.entry_count)
						report_mismatch("entry_count", entry_count, want.entry_count);
					if (min_valid !== want.min_valid)
						report_mismatch("min_valid", min_valid, want.min_valid);
					if (min_id !== want.min_id) report_mismatch("min_id", min_id, want.min_id);
					if (min_deadline !== want.min_deadline)
						report_mismatch("min_deadline", min_deadline, want.min_deadline);
				end
			end
			took_item = start && !busy;
			if (took_item) begin
				c.op = op;
				c.timer_id = timer_id;
				c.deadline = deadline;
				c.bucket_width = bucket_width;
				c.now_time = now_time;
				expected_results.push_back(predict_heap_op(c));
			end
			// Watchdog on cycles with neither an accepted item nor a result.
			if (done || took_item) idle_cycles = 0;
			else idle_cycles++;
		end
	end

	initial begin
		wait (arst_n);
		fork
			begin
				wait (stimulus_done && expected_results.size() == 0);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			wait (idle_cycles >= WATCHDOG_LIMIT && !(stimulus_done && expected_results.size() == 0));
		join_any
		if (idle_cycles >= WATCHDOG_LIMIT || expected_results.size() != 0) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("[timer_min_heap_top] OK");
		end else begin
			$display("[timer_min_heap_top] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
sv/tmh_pkg.sv
sv/tmh_ram.sv
sv/tmh_round.sv
sv/tmh_front.sv
sv/tmh_back.sv
sv/timer_min_heap_top.sv
dv/timer_min_heap_top_tb.sv
